FILE: hdl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the LED chaser and stopwatch block: register
// indexes, reset values, button commands and the control records passed
// between the units.
// ----------------------------------------------------------------------------
package lcs_pkg;

	// Register indexes on the configuration port (byte address is 4 * index).
	localparam logic [2:0] REG_TICK_WHOLE_MS   = 3'd0;
	localparam logic [2:0] REG_TICK_FRAC_US    = 3'd1;
	localparam logic [2:0] REG_WATCH_PERIOD_MS = 3'd2;
	localparam logic [2:0] REG_DELAY_STEP_MS   = 3'd3;
	localparam logic [2:0] REG_DELAY_MIN_MS    = 3'd4;
	localparam logic [2:0] REG_DELAY_MAX_MS    = 3'd5;

	// Register values after reset.
	localparam logic [5:0]  RST_TICK_WHOLE_MS   = 6'd8;
	localparam logic [9:0]  RST_TICK_FRAC_US    = 10'd192;
	localparam logic [9:0]  RST_WATCH_PERIOD_MS = 10'd10;
	localparam logic [15:0] RST_DELAY_STEP_MS   = 16'd100;
	localparam logic [15:0] RST_DELAY_MIN_MS    = 16'd100;
	localparam logic [15:0] RST_DELAY_MAX_MS    = 16'd1000;

	// Microsecond fraction handling.
	localparam logic [9:0]  FRAC_MAX_US = 10'd999;
	localparam logic [10:0] US_PER_MS   = 11'd1000;

	// Accumulator saturation levels.
	localparam logic [16:0] CHASE_ACC_MAX = 17'h1ffff;
	localparam logic [10:0] WATCH_ACC_MAX = 11'h7ff;

	// Chaser pattern constants.
	localparam logic [7:0] LED_ENDS  = 8'h81;
	localparam logic [7:0] LED_UPPER = 8'hf0;
	localparam logic [7:0] LED_LOWER = 8'h0f;
	localparam logic [7:0] LED_FULL  = 8'hff;

	// Stopwatch wrap points (compared before the increment).
	localparam logic [6:0] HUNDREDTHS_LAST = 7'd99;
	localparam logic [5:0] SECONDS_LAST    = 6'd59;
	localparam logic [5:0] MINUTES_LAST    = 6'd59;
	localparam logic [4:0] HOURS_LAST      = 5'd23;

	// Button bit positions in a sample.
	localparam int BTN_START  = 0;
	localparam int BTN_STOP   = 1;
	localparam int BTN_RESET  = 2;
	localparam int BTN_SLOWER = 3;
	localparam int BTN_FASTER = 4;

	// Decoded button command, one per changed sample.
	localparam logic [2:0] CMD_NONE   = 3'd0;
	localparam logic [2:0] CMD_SLOWER = 3'd1;
	localparam logic [2:0] CMD_FASTER = 3'd2;
	localparam logic [2:0] CMD_START  = 3'd3;
	localparam logic [2:0] CMD_STOP   = 3'd4;
	localparam logic [2:0] CMD_CLEAR  = 3'd5;

	// Control for one request being processed.
	typedef struct packed {
		logic       tick;
		logic [2:0] cmd;
	} ctrl_t;

	// Period events raised by a tick.
	typedef struct packed {
		logic chase;
		logic watch;
	} step_t;

endpackage

FILE: hdl/lcs_timebase.sv
// ----------------------------------------------------------------------------
// lcs_timebase
// Elapsed-time accumulators. Each tick adds whole milliseconds plus a
// microsecond fraction and raises at most one chaser and one watch event.
// ----------------------------------------------------------------------------
module lcs_timebase
	import lcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctrl,
	input  logic [5:0]  tick_whole_ms,
	input  logic [9:0]  tick_frac_us,
	input  logic [9:0]  watch_period_ms,
	input  logic [15:0] chase_delay,
	output step_t       step
);

	logic [9:0]  frac_us_acc_q;
	logic [16:0] chase_ms_acc_q;
	logic [10:0] watch_ms_acc_q;

	logic [9:0]  frac;
	logic [10:0] frac_sum;
	logic        frac_carry;
	logic [9:0]  frac_next;
	logic [6:0]  ms;
	logic [17:0] chase_sum;
	logic [16:0] chase_sat;
	logic [11:0] watch_sum;
	logic [10:0] watch_sat;
	logic [16:0] chase_next;
	logic [10:0] watch_next;

	// Fraction carry into the millisecond count.
	always_comb begin
		frac       = (tick_frac_us > FRAC_MAX_US) ? FRAC_MAX_US : tick_frac_us;
		frac_sum   = {1'b0, frac_us_acc_q} + {1'b0, frac};
		frac_carry = (frac_sum >= US_PER_MS);
		frac_next  = frac_carry ? 10'(frac_sum - US_PER_MS) : frac_sum[9:0];
		ms         = {1'b0, tick_whole_ms} + {6'd0, frac_carry};
	end

	// Saturating accumulators, each giving up one period when it is reached.
	always_comb begin
		chase_sum = {1'b0, chase_ms_acc_q} + {11'd0, ms};
		chase_sat = (chase_sum > {1'b0, CHASE_ACC_MAX}) ? CHASE_ACC_MAX : chase_sum[16:0];
		watch_sum = {1'b0, watch_ms_acc_q} + {5'd0, ms};
		watch_sat = (watch_sum > {1'b0, WATCH_ACC_MAX}) ? WATCH_ACC_MAX : watch_sum[10:0];

		step.chase = ctrl.tick && (chase_sat >= {1'b0, chase_delay});
		step.watch = ctrl.tick && (watch_sat >= {1'b0, watch_period_ms});

		chase_next = step.chase ? (chase_sat - {1'b0, chase_delay}) : chase_sat;
		watch_next = step.watch ? (watch_sat - {1'b0, watch_period_ms}) : watch_sat;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_us_acc_q  <= '0;
			chase_ms_acc_q <= '0;
			watch_ms_acc_q <= '0;
		end else if (ctrl.tick) begin
			frac_us_acc_q  <= frac_next;
			chase_ms_acc_q <= chase_next;
			watch_ms_acc_q <= watch_next;
		end
	end

endmodule

FILE: hdl/lcs_chaser.sv
// ----------------------------------------------------------------------------
// lcs_chaser
// LED pattern that fills from both ends toward the middle and then empties
// outward, one step per chaser event.
// ----------------------------------------------------------------------------
module lcs_chaser
	import lcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  step_t      step,
	output logic [7:0] leds_next
);

	logic [7:0] pattern_q;
	logic       filling_q;
	logic [8:0] fill_sum;
	logic [8:0] empty_sum;
	logic       filling_next;

	// Next pattern: the upper half moves down and the lower half up while filling.
	always_comb begin
		fill_sum  = ({1'b0, pattern_q & LED_UPPER} >> 1) + ({1'b0, pattern_q & LED_LOWER} << 1)
			+ {1'b0, LED_ENDS};
		empty_sum = ({1'b0, pattern_q & LED_UPPER} << 1) + ({1'b0, pattern_q & LED_LOWER} >> 1);

		leds_next    = pattern_q;
		filling_next = filling_q;
		if (step.chase) begin
			if (filling_q) begin
				leds_next = (pattern_q == 8'd0) ? LED_ENDS : fill_sum[7:0];
			end else begin
				leds_next = empty_sum[7:0];
			end
			if (leds_next == 8'd0) begin
				filling_next = 1'b1;
			end else if (leds_next == LED_FULL) begin
				filling_next = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			filling_q <= 1'b1;
		end else begin
			pattern_q <= leds_next;
			filling_q <= filling_next;
		end
	end

endmodule

FILE: hdl/lcs_watch.sv
// ----------------------------------------------------------------------------
// lcs_watch
// Stopwatch counters hh:mm:ss:hundredths with start, stop and clear.
// ----------------------------------------------------------------------------
module lcs_watch
	import lcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_t      ctrl,
	input  step_t      step,
	output logic [4:0] hours_next,
	output logic [5:0] minutes_next,
	output logic [5:0] seconds_next,
	output logic [6:0] hundredths_next,
	output logic       running_next
);

	logic [4:0] hours_q;
	logic [5:0] minutes_q;
	logic [5:0] seconds_q;
	logic [6:0] hundredths_q;
	logic       running_q;

	// Counting chain with carries, then the button commands.
	always_comb begin
		hours_next      = hours_q;
		minutes_next    = minutes_q;
		seconds_next    = seconds_q;
		hundredths_next = hundredths_q;
		running_next    = running_q;

		if (step.watch && running_q) begin
			if (hundredths_q >= HUNDREDTHS_LAST) begin
				hundredths_next = '0;
				if (seconds_q >= SECONDS_LAST) begin
					seconds_next = '0;
					if (minutes_q >= MINUTES_LAST) begin
						minutes_next = '0;
						hours_next   = (hours_q >= HOURS_LAST) ? 5'd0 : hours_q + 5'd1;
					end else begin
						minutes_next = minutes_q + 6'd1;
					end
				end else begin
					seconds_next = seconds_q + 6'd1;
				end
			end else begin
				hundredths_next = hundredths_q + 7'd1;
			end
		end

		unique case (ctrl.cmd)
			CMD_START: begin
				running_next = 1'b1;
			end
			CMD_STOP: begin
				running_next = 1'b0;
			end
			CMD_CLEAR: begin
				hours_next      = '0;
				minutes_next    = '0;
				seconds_next    = '0;
				hundredths_next = '0;
				running_next    = 1'b0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hours_q      <= '0;
			minutes_q    <= '0;
			seconds_q    <= '0;
			hundredths_q <= '0;
			running_q    <= 1'b0;
		end else begin
			hours_q      <= hours_next;
			minutes_q    <= minutes_next;
			seconds_q    <= seconds_next;
			hundredths_q <= hundredths_next;
			running_q    <= running_next;
		end
	end

endmodule

FILE: hdl/lcs_speed.sv
// ----------------------------------------------------------------------------
// lcs_speed
// Chaser step delay, raised or lowered by one step per press and held
// within the configured limits.
// ----------------------------------------------------------------------------
module lcs_speed
	import lcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_t       ctrl,
	input  logic [15:0] delay_step_ms,
	input  logic [15:0] delay_min_ms,
	input  logic [15:0] delay_max_ms,
	output logic [15:0] delay_q,
	output logic [15:0] delay_next
);

	logic [16:0] up_sum;
	logic [15:0] down_diff;

	// Saturating add and subtract of the step.
	always_comb begin
		up_sum    = {1'b0, delay_q} + {1'b0, delay_step_ms};
		down_diff = (delay_q > delay_step_ms) ? (delay_q - delay_step_ms) : 16'd0;

		unique case (ctrl.cmd)
			CMD_SLOWER: begin
				if (delay_q >= delay_max_ms || up_sum > {1'b0, delay_max_ms}) begin
					delay_next = delay_max_ms;
				end else begin
					delay_next = up_sum[15:0];
				end
			end
			CMD_FASTER: begin
				if (delay_q <= delay_min_ms || down_diff < delay_min_ms) begin
					delay_next = delay_min_ms;
				end else begin
					delay_next = down_diff;
				end
			end
			default: begin
				delay_next = delay_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= RST_DELAY_MAX_MS;
		end else begin
			delay_q <= delay_next;
		end
	end

endmodule

FILE: hdl/led_chaser_and_stopwatch.sv
// ----------------------------------------------------------------------------
// led_chaser_and_stopwatch
// Stopwatch with a two-ended LED chaser driven by timer ticks and button
// samples, with an APB-style register port.
// ----------------------------------------------------------------------------
// Each request on the input stream is a timer tick (tuser 0) or a new button
// sample (tuser 1, buttons in tdata) and yields exactly one result: LED
// pattern, chaser delay, stopwatch time and running flag after that request.
// A request is registered on entry and processed by combinational
// accumulator, carry and saturation logic into the output register, so one
// request per clock is sustained while the output register is not stalled.
// The input side stalls only while a request is held and the output register
// is stalled. Configuration must be written only while no request is in
// flight; the block itself does not enforce this. Reset restores the register
// defaults and sets the chaser delay to 1000 ms.
// ----------------------------------------------------------------------------
module led_chaser_and_stopwatch
	import lcs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// Configuration port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [4:0] buttons, [7:5] zero
	input  logic [0:0]  s_tuser,   // [0] action
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata    // [7:0] leds, [23:8] delay_ms, [28:24] hours,
	                               // [34:29] minutes, [40:35] seconds,
	                               // [47:41] hundredths, [48] running, [55:49] zero
);

	logic [5:0]  tick_whole_ms_q;
	logic [9:0]  tick_frac_us_q;
	logic [9:0]  watch_period_ms_q;
	logic [15:0] delay_step_ms_q;
	logic [15:0] delay_min_ms_q;
	logic [15:0] delay_max_ms_q;

	logic [2:0]  reg_index;
	logic        reg_write;

	logic        valid_s1;
	logic        action_s1;
	logic [4:0]  buttons_s1;
	logic [4:0]  last_buttons_q;
	logic        advance;
	logic        press;
	ctrl_t       ctrl;
	step_t       step;

	logic [7:0]  leds_next;
	logic [15:0] delay_q;
	logic [15:0] delay_next;
	logic [4:0]  hours_next;
	logic [5:0]  minutes_next;
	logic [5:0]  seconds_next;
	logic [6:0]  hundredths_next;
	logic        running_next;

	// Register port: write on the access cycle, zero-wait reads.
	assign pready    = 1'b1;
	assign reg_index = paddr[4:2];
	assign reg_write = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_whole_ms_q   <= RST_TICK_WHOLE_MS;
			tick_frac_us_q    <= RST_TICK_FRAC_US;
			watch_period_ms_q <= RST_WATCH_PERIOD_MS;
			delay_step_ms_q   <= RST_DELAY_STEP_MS;
			delay_min_ms_q    <= RST_DELAY_MIN_MS;
			delay_max_ms_q    <= RST_DELAY_MAX_MS;
		end else if (reg_write) begin
			unique case (reg_index)
				REG_TICK_WHOLE_MS:   tick_whole_ms_q   <= pwdata[5:0];
				REG_TICK_FRAC_US:    tick_frac_us_q    <= pwdata[9:0];
				REG_WATCH_PERIOD_MS: watch_period_ms_q <= pwdata[9:0];
				REG_DELAY_STEP_MS:   delay_step_ms_q   <= pwdata[15:0];
				REG_DELAY_MIN_MS:    delay_min_ms_q    <= pwdata[15:0];
				REG_DELAY_MAX_MS:    delay_max_ms_q    <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (reg_index)
			REG_TICK_WHOLE_MS:   prdata = {26'd0, tick_whole_ms_q};
			REG_TICK_FRAC_US:    prdata = {22'd0, tick_frac_us_q};
			REG_WATCH_PERIOD_MS: prdata = {22'd0, watch_period_ms_q};
			REG_DELAY_STEP_MS:   prdata = {16'd0, delay_step_ms_q};
			REG_DELAY_MIN_MS:    prdata = {16'd0, delay_min_ms_q};
			REG_DELAY_MAX_MS:    prdata = {16'd0, delay_max_ms_q};
			default:             prdata = '0;
		endcase
	end

	// Input register; it moves on whenever the output register can take a result.
	assign advance  = !m_tvalid || m_tready;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			action_s1  <= s_tuser[0];
			buttons_s1 <= s_tdata[4:0];
		end
	end

	// Decode the request; only a changed button sample acts, with priority slower, faster, start, stop, reset.
	assign press = valid_s1 && advance && action_s1 && (buttons_s1 != last_buttons_q);

	always_comb begin
		ctrl.tick = valid_s1 && advance && !action_s1;
		priority if (!press) begin
			ctrl.cmd = CMD_NONE;
		end else if (buttons_s1[BTN_SLOWER]) begin
			ctrl.cmd = CMD_SLOWER;
		end else if (buttons_s1[BTN_FASTER]) begin
			ctrl.cmd = CMD_FASTER;
		end else if (buttons_s1[BTN_START]) begin
			ctrl.cmd = CMD_START;
		end else if (buttons_s1[BTN_STOP]) begin
			ctrl.cmd = CMD_STOP;
		end else if (buttons_s1[BTN_RESET]) begin
			ctrl.cmd = CMD_CLEAR;
		end else begin
			ctrl.cmd = CMD_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_buttons_q <= '0;
		end else if (press) begin
			last_buttons_q <= buttons_s1;
		end
	end

	lcs_timebase u_timebase (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.tick_whole_ms   (tick_whole_ms_q),
		.tick_frac_us    (tick_frac_us_q),
		.watch_period_ms (watch_period_ms_q),
		.chase_delay     (delay_q),
		.step            (step)
	);

	lcs_chaser u_chaser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.leds_next (leds_next)
	);

	lcs_watch u_watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctrl            (ctrl),
		.step            (step),
		.hours_next      (hours_next),
		.minutes_next    (minutes_next),
		.seconds_next    (seconds_next),
		.hundredths_next (hundredths_next),
		.running_next    (running_next)
	);

	lcs_speed u_speed (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.delay_step_ms (delay_step_ms_q),
		.delay_min_ms  (delay_min_ms_q),
		.delay_max_ms  (delay_max_ms_q),
		.delay_q       (delay_q),
		.delay_next    (delay_next)
	);

	// Output register holding the state after each processed request.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			m_tdata <= {7'd0, running_next, hundredths_next, seconds_next, minutes_next,
				hours_next, delay_next, leds_next};
		end
	end

	// A held request is only ever blocked by a stalled result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (valid_s1 && m_tvalid && !m_tready))
		else $error("input stalled without a stalled result");

	// A request waiting in the input register is not lost or altered.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(action_s1) && $stable(buttons_s1)))
		else $error("waiting request changed");

	// Stopwatch fields delivered stay within their ranges.
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[28:24] <= HOURS_LAST && m_tdata[34:29] <= MINUTES_LAST
			&& m_tdata[40:35] <= SECONDS_LAST && m_tdata[47:41] <= HUNDREDTHS_LAST))
		else $error("stopwatch field out of range");

	// A slower press never leaves the delay above the upper limit.
	a_slower_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.cmd == CMD_SLOWER) |=> (delay_q <= $past(delay_max_ms_q)))
		else $error("delay above upper limit after slower press");

endmodule

FILE: tb/stopwatch_tb_pkg.sv
// ----------------------------------------------------------------------------
// Stopwatch and LED chaser scoreboard
// Types for requests and results, and a scoreboard that keeps its own copy of
// the configuration and state of the block. For each request that the block
// accepts it works out the expected result and queues it. Results leaving
// the block are then compared with that queue, oldest first.
// ----------------------------------------------------------------------------
package stopwatch_tb_pkg;

	import lcs_pkg::*;

	// Request kinds, carried in tuser.
	localparam logic ACT_TICK    = 1'b0;
	localparam logic ACT_BUTTONS = 1'b1;

	// Button samples.
	localparam logic [4:0] PRESS_NONE   = 5'd0;
	localparam logic [4:0] PRESS_START  = 5'(1 << BTN_START);
	localparam logic [4:0] PRESS_STOP   = 5'(1 << BTN_STOP);
	localparam logic [4:0] PRESS_RESET  = 5'(1 << BTN_RESET);
	localparam logic [4:0] PRESS_SLOWER = 5'(1 << BTN_SLOWER);
	localparam logic [4:0] PRESS_FASTER = 5'(1 << BTN_FASTER);
	localparam logic [4:0] PRESS_ALL    = 5'h1f;

	// Only this many mismatches are reported in full.
	localparam int REPORT_LIMIT = 10;

	typedef struct packed {
		logic       action;
		logic [4:0] buttons;
	} request_t;

	// One result as it appears on the result tdata, highest field first.
	typedef struct packed {
		logic [6:0]  spare;
		logic        running;
		logic [6:0]  hundredths;
		logic [5:0]  seconds;
		logic [5:0]  minutes;
		logic [4:0]  hours;
		logic [15:0] delay_ms;
		logic [7:0]  leds;
	} panel_t;

	class stopwatch_scoreboard;

		// Configuration registers.
		logic [5:0]  tick_whole;
		logic [9:0]  tick_frac;
		logic [9:0]  watch_period;
		logic [15:0] delay_step;
		logic [15:0] delay_min;
		logic [15:0] delay_max;

		// Block state.
		logic [9:0]  frac_acc;
		logic [16:0] chase_acc;
		logic [10:0] watch_acc;
		logic [15:0] delay;
		logic [7:0]  leds;
		bit          filling;
		logic [4:0]  last_buttons;
		bit          running;
		logic [6:0]  hundredths;
		logic [5:0]  seconds;
		logic [5:0]  minutes;
		logic [4:0]  hours;

		panel_t expected_panels[$];
		int     faults;

		function new();
			tick_whole   = RST_TICK_WHOLE_MS;
			tick_frac    = RST_TICK_FRAC_US;
			watch_period = RST_WATCH_PERIOD_MS;
			delay_step   = RST_DELAY_STEP_MS;
			delay_min    = RST_DELAY_MIN_MS;
			delay_max    = RST_DELAY_MAX_MS;
			frac_acc     = '0;
			chase_acc    = '0;
			watch_acc    = '0;
			delay        = RST_DELAY_MAX_MS;
			leds         = '0;
			filling      = 1'b1;
			last_buttons = PRESS_NONE;
			running      = 1'b0;
			hundredths   = '0;
			seconds      = '0;
			minutes      = '0;
			hours        = '0;
			faults       = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [31:0] value);
			case (idx)
				REG_TICK_WHOLE_MS:   tick_whole   = value[5:0];
				REG_TICK_FRAC_US:    tick_frac    = value[9:0];
				REG_WATCH_PERIOD_MS: watch_period = value[9:0];
				REG_DELAY_STEP_MS:   delay_step   = value[15:0];
				REG_DELAY_MIN_MS:    delay_min    = value[15:0];
				REG_DELAY_MAX_MS:    delay_max    = value[15:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_panels.size();
		endfunction

		// Advance the state by one accepted request and queue the result.
		function void note_request(request_t req);
			int unsigned frac;
			int unsigned ms;
			int unsigned us;
			int unsigned chase;
			int unsigned watch;
			int unsigned next;
			panel_t      p;
			if (req.action == ACT_BUTTONS) begin
				// A sample acts only when it differs from the last one, and then
				// only its highest-priority button counts.
				if (req.buttons != last_buttons) begin
					last_buttons = req.buttons;
					if (req.buttons[BTN_SLOWER]) begin
						next = delay + delay_step;
						delay = (delay >= delay_max || next > delay_max) ? delay_max : 16'(next);
					end else if (req.buttons[BTN_FASTER]) begin
						next = (delay > delay_step) ? delay - delay_step : 0;
						delay = (delay <= delay_min || next < delay_min) ? delay_min : 16'(next);
					end else if (req.buttons[BTN_START]) begin
						running = 1'b1;
					end else if (req.buttons[BTN_STOP]) begin
						running = 1'b0;
					end else if (req.buttons[BTN_RESET]) begin
						hundredths = '0;
						seconds    = '0;
						minutes    = '0;
						hours      = '0;
						running    = 1'b0;
					end
				end
			end else begin
				// Elapsed time of this tick, with the microsecond carry.
				frac = (tick_frac > FRAC_MAX_US) ? FRAC_MAX_US : tick_frac;
				ms = tick_whole;
				us = frac_acc + frac;
				if (us >= US_PER_MS) begin
					us -= US_PER_MS;
					ms++;
				end
				frac_acc = 10'(us);
				chase = chase_acc + ms;
				if (chase > CHASE_ACC_MAX)
					chase = CHASE_ACC_MAX;
				watch = watch_acc + ms;
				if (watch > WATCH_ACC_MAX)
					watch = WATCH_ACC_MAX;

				// At most one chaser step per tick.
				if (chase >= delay) begin
					chase -= delay;
					if (filling)
						leds = (leds == '0) ? LED_ENDS :
							((leds & LED_UPPER) >> 1) + ((leds & LED_LOWER) << 1) + LED_ENDS;
					else
						leds = ((leds & LED_UPPER) << 1) + ((leds & LED_LOWER) >> 1);
					if (leds == '0)
						filling = 1'b1;
					else if (leds == LED_FULL)
						filling = 1'b0;
				end
				chase_acc = 17'(chase);

				// At most one stopwatch count per tick, and only while running.
				if (watch >= watch_period) begin
					watch -= watch_period;
					if (running) begin
						if (hundredths == HUNDREDTHS_LAST) begin
							hundredths = '0;
							if (seconds == SECONDS_LAST) begin
								seconds = '0;
								if (minutes == MINUTES_LAST) begin
									minutes = '0;
									hours = (hours == HOURS_LAST) ? '0 : hours + 5'd1;
								end else begin
									minutes++;
								end
							end else begin
								seconds++;
							end
						end else begin
							hundredths++;
						end
					end
				end
				watch_acc = 11'(watch);
			end

			p            = '0;
			p.leds       = leds;
			p.delay_ms   = delay;
			p.hours      = hours;
			p.minutes    = minutes;
			p.seconds    = seconds;
			p.hundredths = hundredths;
			p.running    = running;
			expected_panels.push_back(p);
		endfunction

		// Compare one result from the block with the oldest expectation.
		function void check_result(logic [55:0] data);
			panel_t got;
			panel_t want;
			got = data;
			if (expected_panels.size() == 0) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("result %h arrived with no request outstanding", data);
				return;
			end
			want = expected_panels.pop_front();
			if (got.leds !== want.leds || got.delay_ms !== want.delay_ms ||
			    got.hours !== want.hours || got.minutes !== want.minutes ||
			    got.seconds !== want.seconds || got.hundredths !== want.hundredths ||
			    got.running !== want.running || got.spare !== want.spare) begin
				faults++;
				if (faults <= REPORT_LIMIT)
					$display("mismatch: expected leds %h delay %0d time %0d:%0d:%0d.%0d run %b spare %h, got leds %h delay %0d time %0d:%0d:%0d.%0d run %b spare %h",
						want.leds, want.delay_ms, want.hours, want.minutes, want.seconds,
						want.hundredths, want.running, want.spare,
						got.leds, got.delay_ms, got.hours, got.minutes, got.seconds,
						got.hundredths, got.running, got.spare);
			end
		endfunction

	endclass

endpackage

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Stopwatch and LED chaser testbench
// Drives timer ticks and button samples into the block through the request
// stream, with bursts and gaps on the sending side and a changing stall
// pattern on the result side. A short directed sequence covers every button
// and the priority between them. Random phases then follow under several
// register settings: extremes, zero periods, an oversized fraction, crossed
// delay limits and saturating accumulators, and finally a run of ticks with
// a zero chaser delay, so that the chaser accumulator keeps growing. Every
// result is checked against the scoreboard's own prediction.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	import lcs_pkg::*;
	import stopwatch_tb_pkg::*;

	localparam int CYCLE_LIMIT       = 300000;
	localparam int PHASE_ITEMS       = 120;
	localparam int LAST_RANDOM_PHASE = 10;
	localparam int SOAK_PHASE        = 11;
	localparam int SOAK_TICKS        = 300;
	localparam int SETTLE_CYCLES     = 4;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;   // [4:0] buttons, [7:5] zero
	logic [0:0]  s_tuser  = '0;   // [0] action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;         // [7:0] leds, [23:8] delay_ms, [28:24] hours,
	                              // [34:29] minutes, [40:35] seconds,
	                              // [47:41] hundredths, [48] running, [55:49] zero

	stopwatch_scoreboard board = new();

	// Last button sample handed to the block, so that presses and releases
	// can be generated as well-formed pairs.
	logic [4:0] last_sample = PRESS_NONE;

	int stall_mode = 0;
	int stall_left = 0;

	led_chaser_and_stopwatch dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// The receiver switches between free flow, light and heavy random stalls
	// and a regular, periodic stall.
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(20, 200);
		end
		case (stall_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			2: m_tready <= ($urandom_range(0, 3) == 0);
			default: m_tready <= (stall_left % 3 != 0);
		endcase
		stall_left--;
	end

	// Every result leaving the block is checked.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata);
	end

	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("simulation failed");
		$finish;
	end

	// Present one request and hold it until the block takes it.
	task automatic send_request(input request_t req);
		s_tvalid <= 1'b1;
		s_tuser  <= req.action;
		s_tdata  <= {3'b000, req.buttons};
		do @(posedge clk); while (!s_tready);
		board.note_request(req);
	endtask

	// Send requests in bursts of random length, with random gaps between
	// them unless this run is to go without gaps.
	task automatic send_items(input request_t reqs[$]);
		int burst;
		bit steady;
		burst  = 0;
		steady = ($urandom_range(0, 3) == 0);
		foreach (reqs[i]) begin
			if (burst == 0) begin
				if (!steady && i != 0) begin
					s_tvalid <= 1'b0;
					repeat ($urandom_range(1, 6)) @(posedge clk);
				end
				burst = $urandom_range(1, 24);
			end
			send_request(reqs[i]);
			burst--;
		end
	endtask

	// Let every outstanding result drain, then a few more cycles.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		board.set_reg(idx, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Register settings for each phase of the run.
	task automatic apply_settings(input int phase);
		logic [31:0] whole;
		logic [31:0] frac;
		logic [31:0] period;
		logic [31:0] step;
		logic [31:0] lo;
		logic [31:0] hi;
		wait_idle();
		case (phase)
			// Smallest values throughout.
			1: begin
				whole = 1; frac = 0; period = 2; step = 1; lo = 2; hi = 40;
			end
			// Largest values throughout.
			2: begin
				whole = 63; frac = 999; period = 1023; step = 65535; lo = 64; hi = 65535;
			end
			// Stopwatch period of zero, a fraction above 999 and a delay that
			// can fall to zero.
			3: begin
				whole = $urandom_range(1, 63); frac = 1023; period = 0;
				step = 65535; lo = 0; hi = 50;
			end
			// Lower delay limit above the upper one.
			4: begin
				whole = 8; frac = $urandom_range(0, 999); period = 10;
				step = 150; lo = 500; hi = 200;
			end
			// Periods at or below the tick, so that both accumulators grow.
			5: begin
				whole = 40; frac = 500; period = 10; step = 5; lo = 20; hi = 35;
			end
			// Zero chaser delay, so that the chaser accumulator keeps growing.
			SOAK_PHASE: begin
				whole = 63; frac = 999; period = 1023; step = 65535; lo = 0; hi = 0;
			end
			default: begin
				whole  = $urandom_range(1, 63);
				frac   = $urandom_range(0, 999);
				period = whole + $urandom_range(1, 40);
				step   = $urandom_range(1, 400);
				lo     = whole + $urandom_range(1, 120);
				hi     = lo + $urandom_range(0, 1200);
			end
		endcase
		write_reg(REG_TICK_WHOLE_MS, whole);
		write_reg(REG_TICK_FRAC_US, frac);
		write_reg(REG_WATCH_PERIOD_MS, period);
		write_reg(REG_DELAY_STEP_MS, step);
		write_reg(REG_DELAY_MIN_MS, lo);
		write_reg(REG_DELAY_MAX_MS, hi);
	endtask

	// Random requests: mostly ticks, and button samples that are mostly a
	// single press followed by its release, the rest random noise.
	task automatic gen_requests(input int count, input int button_pct, ref request_t reqs[$]);
		request_t req;
		repeat (count) begin
			req.buttons = 5'($urandom_range(0, 31));
			if ($urandom_range(1, 100) > button_pct) begin
				req.action = ACT_TICK;
			end else begin
				req.action = ACT_BUTTONS;
				if ($urandom_range(0, 9) < 7) begin
					if (last_sample != PRESS_NONE)
						req.buttons = PRESS_NONE;
					else
						req.buttons = 5'(1 << $urandom_range(BTN_START, BTN_FASTER));
				end
				last_sample = req.buttons;
			end
			reqs.push_back(req);
		end
	endtask

	initial begin
		request_t reqs[$];

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part under the reset settings: every button alone, the
		// priority between them and a repeated sample.
		reqs.push_back(request_t'{ACT_TICK, PRESS_NONE});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_START});
		reqs.push_back(request_t'{ACT_TICK, PRESS_ALL});
		reqs.push_back(request_t'{ACT_TICK, PRESS_NONE});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_NONE});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_STOP});
		reqs.push_back(request_t'{ACT_TICK, PRESS_NONE});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_START});
		reqs.push_back(request_t'{ACT_TICK, PRESS_NONE});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_RESET});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_SLOWER});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_FASTER});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_SLOWER | PRESS_FASTER});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_ALL});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_ALL & ~PRESS_SLOWER});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_START | PRESS_STOP | PRESS_RESET});
		reqs.push_back(request_t'{ACT_TICK, PRESS_NONE});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_STOP | PRESS_RESET});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_START | PRESS_RESET});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_RESET});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_RESET});
		reqs.push_back(request_t'{ACT_TICK, PRESS_NONE});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_NONE});
		send_items(reqs);
		last_sample = PRESS_NONE;

		// Random phases, the first under the reset settings.
		for (int phase = 0; phase <= LAST_RANDOM_PHASE; phase++) begin
			if (phase != 0)
				apply_settings(phase);
			reqs.delete();
			gen_requests(PHASE_ITEMS, 35, reqs);
			send_items(reqs);
		end

		// Chaser delay forced to zero, then a stretch of ticks.
		apply_settings(SOAK_PHASE);
		reqs.delete();
		if (last_sample == PRESS_FASTER)
			reqs.push_back(request_t'{ACT_BUTTONS, PRESS_NONE});
		reqs.push_back(request_t'{ACT_BUTTONS, PRESS_FASTER});
		last_sample = PRESS_FASTER;
		gen_requests(SOAK_TICKS, 3, reqs);
		send_items(reqs);

		wait_idle();
		if (board.faults == 0 && board.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
